/* hw/rtl/isqrt_pkg.sv */
`timescale 1ns / 1ps

package isqrt_pkg;

	localparam int ROOT_WIDTH = 16;
	localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = '1;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} isqrt_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} isqrt_cmd_t;

endpackage

/* hw/rtl/isqrt_dp.sv */
`timescale 1ns / 1ps

module isqrt_dp
	import isqrt_pkg::*;
#(
	parameter int RADICAND_WIDTH = 32
) (
	input  logic                      clk,
	input  isqrt_cmd_t                cmd,
	input  logic [RADICAND_WIDTH-1:0] radicand,
	output logic [ROOT_WIDTH-1:0]     root
);

	localparam int W       = RADICAND_WIDTH;
	localparam int TOP_RAW = ((W - 1) / 2) * 2;
	localparam int TOP_POS = (TOP_RAW > 62) ? 62 : TOP_RAW;
	localparam logic [W-1:0] TOP_BIT = {{(W-1){1'b0}}, 1'b1} << TOP_POS;

	logic [W-1:0]  rem_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  bit_q;
	logic [W:0]    trial;
	logic          take;
	logic [W-1:0]  rem_next;
	logic [W-1:0]  acc_next;
	logic [64:0]   acc_ext;
	logic [ROOT_WIDTH-1:0] root_q;

	// one base-4 digit per step
	always_comb begin
		trial = {1'b0, acc_q} + {1'b0, bit_q};
		take  = ({1'b0, rem_q} >= trial);
		if (take) begin
			rem_next = rem_q - trial[W-1:0];
			acc_next = (acc_q >> 1) + bit_q;
		end else begin
			rem_next = rem_q;
			acc_next = acc_q >> 1;
		end
		acc_ext = {{(65-W){1'b0}}, acc_next};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= radicand;
			acc_q <= '0;
			bit_q <= TOP_BIT;
		end else if (cmd.step) begin
			rem_q <= rem_next;
			acc_q <= acc_next;
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (acc_ext > {{(65-ROOT_WIDTH){1'b0}}, ROOT_MAX})
				root_q <= ROOT_MAX;
			else
				root_q <= acc_ext[ROOT_WIDTH-1:0];
		end
	end

	assign root = root_q;

endmodule

/* hw/rtl/isqrt_ctrl.sv */
`timescale 1ns / 1ps

module isqrt_ctrl
	import isqrt_pkg::*;
#(
	parameter int NSTEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output isqrt_cmd_t cmd
);

	localparam int CW = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(NSTEPS - 1);

	isqrt_state_t state_q, state_next;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          slot_free;
	logic          done;

	assign slot_free = !out_valid_q || out_ready;
	assign done      = (cnt_q == '0) && slot_free;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_next = ST_CALC;
			end
			ST_CALC: begin
				if (done)
					state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CALC: begin
				// final digit and result capture share a cycle
				cmd.step    = (cnt_q != '0) || slot_free;
				cmd.capture = done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load)
				cnt_q <= LAST;
			else if (cmd.step && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.capture)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_capture_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || out_ready))
		else $error("result captured over a waiting transaction");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CALC && cnt_q == LAST))
		else $error("step count not loaded on accept");

	a_capture_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid_q)
		else $error("captured result not presented");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !cmd.load)
		else $error("load while a root is in progress");

endmodule

/* hw/rtl/integer_square_root.sv */
`timescale 1ns / 1ps

// Floor square root of an unsigned radicand by the base-4 digit method. One
// transaction on s_axis carries a radicand; one transaction on m_axis returns
// its 16-bit root, saturated at 65535 when RADICAND_WIDTH exceeds 32. A single
// compare-subtract unit resolves one root bit per cycle, except where the final
// digit is held; an item is loaded and then takes one step per digit, with at
// most 32 digits. A new radicand is taken while the previous root waits on
// m_axis; the final digit waits only if that root is still unaccepted. Radicand
// bits above RADICAND_WIDTH are ignored.

module integer_square_root
	import isqrt_pkg::*;
#(
	parameter int RADICAND_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// radicand
	input  logic [((RADICAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// root
	output logic [ROOT_WIDTH-1:0]               m_axis_tdata
);

	localparam int TOP_RAW = ((RADICAND_WIDTH - 1) / 2) * 2;
	localparam int TOP_POS = (TOP_RAW > 62) ? 62 : TOP_RAW;
	localparam int NSTEPS  = TOP_POS / 2 + 1;

	isqrt_cmd_t cmd;

	isqrt_ctrl #(
		.NSTEPS(NSTEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd)
	);

	isqrt_dp #(
		.RADICAND_WIDTH(RADICAND_WIDTH)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.radicand(s_axis_tdata[RADICAND_WIDTH-1:0]),
		.root    (m_axis_tdata)
	);

endmodule

/* dv/isqrt_checker.sv */
`timescale 1ns / 1ps

module isqrt_checker
	import isqrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// radicand
	input  logic [31:0]           s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// root
	input  logic [ROOT_WIDTH-1:0] m_axis_tdata,
	output int                    mismatches,
	output int                    pending
);

	localparam logic [31:0] TOP_TRIAL = 32'h4000_0000;

	logic [ROOT_WIDTH-1:0] expected_roots [$];

	function automatic logic [ROOT_WIDTH-1:0] floor_root(input logic [31:0] radicand);
		logic [31:0] remainder;
		logic [31:0] partial;
		logic [31:0] trial_bit;
		logic [31:0] trial_sum;
		remainder = radicand;
		partial   = '0;
		trial_bit = TOP_TRIAL;
		while (trial_bit > remainder)
			trial_bit = trial_bit >> 2;
		while (trial_bit != 0) begin
			trial_sum = partial + trial_bit;
			if (remainder >= trial_sum) begin
				remainder = remainder - trial_sum;
				partial   = partial + (trial_bit << 1);
			end
			partial   = partial >> 1;
			trial_bit = trial_bit >> 2;
		end
		if (partial > 32'(ROOT_MAX))
			partial = 32'(ROOT_MAX);
		return partial[ROOT_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [ROOT_WIDTH-1:0] want;
		if (!arst_n) begin
			expected_roots.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_roots.push_back(floor_root(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_roots.size() == 0) begin
					$error("root: unexpected transaction, got %0d", m_axis_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_roots.pop_front();
					if (m_axis_tdata !== want) begin
						$error("root: expected %0d, got %0d", want, m_axis_tdata);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_roots.size();
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb
	import isqrt_pkg::*;
();

	localparam int RANDOM_ITEMS   = 950;
	localparam int MAX_GAP        = 17;
	localparam int LONG_HOLD      = 500;
	localparam int HOLD_AT_RESULT = 300;
	localparam int STUCK_LIMIT    = 3000;
	localparam int TAIL_CYCLES    = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [ROOT_WIDTH-1:0] m_axis_tdata;
	int                    mismatches;
	int                    pending;
	int                    stuck_cycles;
	bit                    send_steady;
	logic [31:0]           corner_vals [$];

	integer_square_root DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	isqrt_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_radicand(input logic [31:0] radicand);
		int unsigned gap;
		gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= radicand;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// stop offering and let every outstanding root come back
	task automatic drain_roots();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] random_radicand();
		logic [31:0] k;
		k = $urandom_range(0, 65535);
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2:    return $urandom >> $urandom_range(0, 31);
			3:    return k * k;
			4:    return k * k - 1;
			default: return k * k + $urandom_range(0, 2 * k);
		endcase
	endfunction

	// receiver: random back-pressure, steady stretches and one long hold-off
	initial begin
		int unsigned hold;
		int          taken;
		bit          rx_steady;
		taken     = 0;
		rx_steady = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			if (taken == HOLD_AT_RESULT)
				hold = LONG_HOLD;
			else
				hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			taken++;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		send_steady   = 1'b0;
		corner_vals   = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16, 32'd17,
			32'h0000_FFFF, 32'h0001_0000, 32'd999_999, 32'd1_000_000, 32'h3FFF_FFFF,
			32'h4000_0000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0000,
			32'hFFFE_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_vals[i])
			send_radicand(corner_vals[i]);
		drain_roots();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				send_steady = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				drain_roots();
			send_radicand(random_radicand());
		end

		drain_roots();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
